[src/i2c_master_byte_engine_assert.svh]
// ---------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Concurrent check wrappers, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2CM_ASSERT_IMPLY(lbl, ante, cons, msg)
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/i2cm_pkg.sv]
// ---------------------------------------------------------------------------
// I2C master byte engine package
// Operation codes, sequencer states, step constants and shared types.
// ---------------------------------------------------------------------------
package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int STEP_W        = 5;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [STEP_W-1:0] START_SDA_HI  = STEP_W'(0);
  localparam logic [STEP_W-1:0] START_SCL_HI  = STEP_W'(1);
  localparam logic [STEP_W-1:0] START_SDA_LO  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STOP_SDA_LO   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STOP_SCL_HI   = STEP_W'(1);
  localparam logic [STEP_W-1:0] WR_ACK_STEP   = STEP_W'(3 * BITS_PER_BYTE);
  localparam logic [STEP_W-1:0] RD_DATA_STEPS = STEP_W'(2 * BITS_PER_BYTE);
  localparam logic [STEP_W-1:0] RD_LAST_BIT   = STEP_W'(2 * BITS_PER_BYTE - 2);
  localparam logic [STEP_W-1:0] RD_ACK_STEP   = STEP_W'(2 * BITS_PER_BYTE);
  localparam logic [STEP_W-1:0] RD_SCL_STEP   = STEP_W'(2 * BITS_PER_BYTE + 1);

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_STOP  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PH_SET  = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef struct packed {
    op_t                      op;
    logic [BITS_PER_BYTE-1:0] tx_byte;
    logic                     send_ack;
    logic                     sda_in;
  } tick_t;

endpackage

[src/i2cm_front.sv]
// ---------------------------------------------------------------------------
// I2C master front end
// Takes tick requests, folds unknown operation codes into none and
// pushes the classified tick into the queue.
// ---------------------------------------------------------------------------
module i2cm_front (
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_operation,
  input  logic [i2cm_pkg::BITS_PER_BYTE-1:0] in_tx_byte,
  input  logic                              in_send_ack,
  input  logic                              in_sda_in,
  input  logic                              q_full,
  output logic                              q_push,
  output i2cm_pkg::tick_t                   q_wdata
);

  i2cm_pkg::op_t op_cls;

  always_comb begin
    if (in_operation inside {i2cm_pkg::OP_START, i2cm_pkg::OP_STOP,
                             i2cm_pkg::OP_WRITE, i2cm_pkg::OP_READ}) begin
      op_cls = i2cm_pkg::op_t'(in_operation);
    end else begin
      op_cls = i2cm_pkg::OP_NONE;
    end
  end

  assign in_stall         = q_full;
  assign q_push           = in_valid && !q_full;
  assign q_wdata.op       = op_cls;
  assign q_wdata.tx_byte  = in_tx_byte;
  assign q_wdata.send_ack = in_send_ack;
  assign q_wdata.sda_in   = in_sda_in;

endmodule

[src/i2cm_queue.sv]
// ---------------------------------------------------------------------------
// I2C master tick queue
// Short register queue between front end and sequencer.
// ---------------------------------------------------------------------------
module i2cm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2cm_pkg::tick_t wdata,
  input  logic            pop,
  output logic            q_valid,
  output logic            full,
  output i2cm_pkg::tick_t rdata
);

  i2cm_pkg::tick_t                  entry_r [i2cm_pkg::QUEUE_DEPTH];
  logic [i2cm_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [i2cm_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [i2cm_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign full    = (count_r == i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH));
  assign rdata   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[src/i2cm_back.sv]
// ---------------------------------------------------------------------------
// I2C master sequencer
// Steps the active operation by one quarter-bit tick per popped request
// and registers the bus state for the result channel.
// ---------------------------------------------------------------------------
module i2cm_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  i2cm_pkg::tick_t                    q_rdata,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_scl_level,
  output logic                               out_sda_level,
  output logic                               out_sda_driven,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic                               out_ack_seen,
  output logic [i2cm_pkg::BITS_PER_BYTE-1:0] out_read_byte
);

  localparam int BW = i2cm_pkg::BITS_PER_BYTE;

  i2cm_pkg::state_t           st_r, st_nxt, cur_st;
  logic [i2cm_pkg::STEP_W-1:0] step_r, step_nxt;
  i2cm_pkg::phase_t           ph_r, ph_nxt, ph;
  logic [BW-1:0]              shift_r, shift_nxt, shift;
  logic                       scl_r, scl_nxt, scl_v;
  logic                       sda_r, sda_nxt, sda_v;
  logic                       sda_en_r, sda_en_nxt, sda_en_v;
  logic                       ack_r, ack_nxt;
  logic                       ack_tx_r, ack_tx_nxt;
  logic [BW-1:0]              rx_r, rx_nxt;
  logic                       busy, done;
  logic                       out_valid_r, out_valid_nxt;
  logic                       o_scl_r, o_sda_r, o_sda_en_r, o_busy_r, o_done_r, o_ack_r;
  logic [BW-1:0]              o_rx_r;

  assign pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    cur_st     = st_r;
    ph         = ph_r;
    shift      = shift_r;
    scl_v      = scl_r;
    sda_v      = sda_r;
    sda_en_v   = sda_en_r;
    ack_nxt    = ack_r;
    ack_tx_nxt = ack_tx_r;
    rx_nxt     = rx_r;
    busy       = 1'b0;
    done       = 1'b0;
    step_nxt   = step_r;

    if (st_r == i2cm_pkg::ST_IDLE && q_rdata.op != i2cm_pkg::OP_NONE) begin
      step_nxt = '0;
      ph       = i2cm_pkg::PH_SET;
      case (q_rdata.op)
        i2cm_pkg::OP_START: cur_st = i2cm_pkg::ST_START;
        i2cm_pkg::OP_STOP:  cur_st = i2cm_pkg::ST_STOP;
        i2cm_pkg::OP_WRITE: begin
          cur_st = i2cm_pkg::ST_WRITE;
          shift  = q_rdata.tx_byte;
        end
        i2cm_pkg::OP_READ: begin
          cur_st     = i2cm_pkg::ST_READ;
          shift      = '0;
          ack_tx_nxt = q_rdata.send_ack;
        end
        default: cur_st = i2cm_pkg::ST_IDLE;
      endcase
    end

    case (cur_st)
      i2cm_pkg::ST_START: begin
        busy = 1'b1;
        if (step_nxt == i2cm_pkg::START_SDA_HI) begin
          sda_v = 1'b1;
        end else if (step_nxt == i2cm_pkg::START_SCL_HI) begin
          scl_v = 1'b1;
        end else if (step_nxt == i2cm_pkg::START_SDA_LO) begin
          sda_v = 1'b0;
        end else begin
          scl_v = 1'b0;
          done  = 1'b1;
        end
      end
      i2cm_pkg::ST_STOP: begin
        busy = 1'b1;
        if (step_nxt == i2cm_pkg::STOP_SDA_LO) begin
          sda_v = 1'b0;
        end else if (step_nxt == i2cm_pkg::STOP_SCL_HI) begin
          scl_v = 1'b1;
        end else begin
          sda_v = 1'b1;
          done  = 1'b1;
        end
      end
      i2cm_pkg::ST_WRITE: begin
        busy = 1'b1;
        if (step_nxt < i2cm_pkg::WR_ACK_STEP) begin
          case (ph)
            i2cm_pkg::PH_SET: begin
              sda_v = shift[BW-1];
              shift = {shift[BW-2:0], 1'b0};
              ph    = i2cm_pkg::PH_HIGH;
            end
            i2cm_pkg::PH_HIGH: begin
              scl_v = 1'b1;
              ph    = i2cm_pkg::PH_LOW;
            end
            default: begin
              scl_v = 1'b0;
              ph    = i2cm_pkg::PH_SET;
            end
          endcase
        end else if (step_nxt == i2cm_pkg::WR_ACK_STEP) begin
          sda_en_v = 1'b0;
          scl_v    = 1'b1;
          ack_nxt  = !q_rdata.sda_in;
        end else begin
          scl_v = 1'b0;
          done  = 1'b1;
        end
      end
      i2cm_pkg::ST_READ: begin
        busy = 1'b1;
        if (step_nxt < i2cm_pkg::RD_DATA_STEPS) begin
          if (!step_nxt[0]) begin
            sda_en_v = 1'b0;
            scl_v    = 1'b1;
            shift    = {shift[BW-2:0], q_rdata.sda_in};
            if (step_nxt == i2cm_pkg::RD_LAST_BIT) begin
              rx_nxt = shift;
            end
          end else begin
            scl_v = 1'b0;
          end
        end else if (step_nxt == i2cm_pkg::RD_ACK_STEP) begin
          sda_en_v = 1'b1;
          sda_v    = !ack_tx_nxt;
        end else if (step_nxt == i2cm_pkg::RD_SCL_STEP) begin
          scl_v = 1'b1;
        end else begin
          scl_v = 1'b0;
          done  = 1'b1;
        end
      end
      default: busy = 1'b0;
    endcase

    st_nxt     = cur_st;
    ph_nxt     = ph;
    shift_nxt  = shift;
    scl_nxt    = scl_v;
    sda_nxt    = sda_v;
    sda_en_nxt = sda_en_v;
    if (busy) begin
      if (done) begin
        if (cur_st == i2cm_pkg::ST_WRITE) begin
          sda_en_nxt = 1'b1;
        end
        if (cur_st == i2cm_pkg::ST_READ) begin
          sda_nxt = 1'b1;
        end
        st_nxt   = i2cm_pkg::ST_IDLE;
        step_nxt = '0;
      end else begin
        step_nxt = step_nxt + 1'b1;
      end
    end

    out_valid_nxt = pop ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= i2cm_pkg::ST_IDLE;
      step_r      <= '0;
      ph_r        <= i2cm_pkg::PH_SET;
      shift_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      sda_en_r    <= 1'b1;
      ack_r       <= 1'b0;
      ack_tx_r    <= 1'b0;
      rx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        st_r     <= st_nxt;
        step_r   <= step_nxt;
        ph_r     <= ph_nxt;
        shift_r  <= shift_nxt;
        scl_r    <= scl_nxt;
        sda_r    <= sda_nxt;
        sda_en_r <= sda_en_nxt;
        ack_r    <= ack_nxt;
        ack_tx_r <= ack_tx_nxt;
        rx_r     <= rx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      o_scl_r    <= scl_v;
      o_sda_r    <= sda_v;
      o_sda_en_r <= sda_en_v;
      o_busy_r   <= busy;
      o_done_r   <= done;
      o_ack_r    <= ack_nxt;
      o_rx_r     <= rx_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = o_scl_r;
  assign out_sda_level  = o_sda_r;
  assign out_sda_driven = o_sda_en_r;
  assign out_busy_res   = o_busy_r;
  assign out_done_res   = o_done_r;
  assign out_ack_seen   = o_ack_r;
  assign out_read_byte  = o_rx_r;

endmodule

[src/i2c_master_byte_engine.sv]
// ---------------------------------------------------------------------------
// I2C master byte engine
// Bit-banged I2C master sequencer, one quarter-bit tick per request.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in_     | input     | in_valid/in_stall  | operation, tx_byte, send_ack, sda_in
//   out_    | output    | out_valid/out_stall| bus levels, busy, done, ack, byte
//
// One tick request per cycle sustained while in_stall stays low; each result
// passes through the two-entry tick queue and then the result register.
// Reset is synchronous on rst_n: bus lines idle high, SDA driven, no operation.
// out_stall holds the result register and backs up into the queue; in_stall
// rises only when the queue is full.
// ---------------------------------------------------------------------------
`include "i2c_master_byte_engine_assert.svh"

module i2c_master_byte_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         in_operation,
  input  logic [i2cm_pkg::BITS_PER_BYTE-1:0] in_tx_byte,
  input  logic                               in_send_ack,
  input  logic                               in_sda_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_scl_level,
  output logic                               out_sda_level,
  output logic                               out_sda_driven,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic                               out_ack_seen,
  output logic [i2cm_pkg::BITS_PER_BYTE-1:0] out_read_byte
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  i2cm_pkg::tick_t q_wdata;
  i2cm_pkg::tick_t q_rdata;

  i2cm_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_tx_byte   (in_tx_byte),
    .in_send_ack  (in_send_ack),
    .in_sda_in    (in_sda_in),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  i2cm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .pop     (q_pop),
    .q_valid (q_valid),
    .full    (q_full),
    .rdata   (q_rdata)
  );

  i2cm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_rdata        (q_rdata),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scl_level  (out_scl_level),
    .out_sda_level  (out_sda_level),
    .out_sda_driven (out_sda_driven),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_ack_seen   (out_ack_seen),
    .out_read_byte  (out_read_byte)
  );

  `I2CM_ASSERT_IMPLY(a_done_busy, out_valid && out_done_res, out_busy_res, "done without busy")
  `I2CM_ASSERT_NEXT(a_pop_shows, q_pop, out_valid, "popped tick not shown on result")
  `I2CM_ASSERT_NEXT(a_accept_queued, in_valid && !in_stall, q_valid, "accepted tick not queued")

endmodule
